// ===== rtl/frame_rate_moving_average_defines.svh =====
// ----------------------------------------------------------------------------
// Frame rate moving average: assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_MOVING_AVERAGE_DEFINES_SVH
`define FRAME_RATE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FRMA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FRMA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/frma_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame rate moving average: package
// Widths, constants, payload types and state encoding shared by the block.
// ----------------------------------------------------------------------------
package frma_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 8;
    localparam int RATE_W  = 18;
    localparam int SPEED_W = 32;

    // Window depth default
    localparam int WINDOW_DEF = 16;

    // Rate constants: 1000 fps in Q10.8
    localparam logic [RATE_W-1:0] RATE_MAX_Q8 = 18'd256000;

    // Speed math: floor(prod * 65536 / 1000) == floor(prod * SPEED_RECIP / 2^33)
    // for every product below the saturation limit. The reciprocal is applied
    // in two halves on consecutive cycles.
    localparam int PROD_W       = TIME_W + GAIN_W;
    localparam int PROD_KEEP_W  = 26;
    localparam int RECIP_W      = 40;
    localparam int RECIP_HALF_W = 20;
    localparam int RECIP_SHIFT  = 33;
    localparam logic [RECIP_W-1:0] SPEED_RECIP = 40'd562949953422;
    localparam int PART_W       = PROD_KEEP_W + RECIP_HALF_W;
    localparam int ACC_W        = PART_W + RECIP_HALF_W;
    // Products at or above this saturate the Q16 speed
    localparam logic [PROD_W-1:0] SPEED_SAT_LIMIT = 40'd65536000;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN = 1'b1;
    localparam logic [GAIN_W-1:0] MOVE_GAIN_RST = 8'd5;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST = 8'd3;

    // Opcodes
    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Derived window widths
    function automatic int idx_width(input int window);
        return (window > 1) ? $clog2(window) : 1;
    endfunction

    function automatic int fill_width(input int window);
        return $clog2(window + 1);
    endfunction

    function automatic int sum_width(input int window);
        return RATE_W + $clog2(window);
    endfunction

    // Payload types
    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] time_ms;
    } frame_item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  average_rate;
        logic [SPEED_W-1:0] move_speed;
        logic [SPEED_W-1:0] turn_speed;
    } result_item_t;

    // Window store control
    typedef struct packed {
        logic clear;
        logic rd;
        logic upd;
    } win_ctrl_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_UPD,
        ST_AVGGO,
        ST_AVG
    } state_t;

endpackage

// ===== rtl/frma_div.sv =====
// ----------------------------------------------------------------------------
// Frame rate moving average: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frma_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             rem_ge;

    // Trial subtract of the shifted partial remainder
    assign rem_shift = {rem_reg, quot_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den};
    assign rem_ge    = (rem_shift >= {1'b0, den});

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quot_next = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], rem_ge};
            rem_next  = rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/frma_window.sv =====
// ----------------------------------------------------------------------------
// Frame rate moving average: rate window store
// Ring memory of rates with write slot, fill count and running sum.
// ----------------------------------------------------------------------------
module frma_window #(
    parameter int WINDOW = frma_pkg::WINDOW_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  frma_pkg::win_ctrl_t                      ctrl,
    input  logic [frma_pkg::RATE_W-1:0]              rate,
    output logic [frma_pkg::sum_width(WINDOW)-1:0]   sum,
    output logic [frma_pkg::fill_width(WINDOW)-1:0]  fill
);

    import frma_pkg::*;

    localparam int IDX_W  = idx_width(WINDOW);
    localparam int FILL_W = fill_width(WINDOW);
    localparam int SUM_W  = sum_width(WINDOW);

    logic [RATE_W-1:0] mem [WINDOW];
    logic [RATE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              full;
    logic [SUM_W-1:0]  evict;

    assign full  = (fill_reg == FILL_W'(WINDOW));
    assign evict = full ? SUM_W'(rd_data_reg) : '0;

    // Clear on init, advance slot, fill and sum on update
    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (ctrl.clear)
        begin
            slot_next = '0;
            fill_next = '0;
            sum_next  = '0;
        end
        else if (ctrl.upd)
        begin
            sum_next  = sum_reg - evict + SUM_W'(rate);
            fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
            slot_next = (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // Memory: write the new rate, read the entry it replaces
    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            mem[slot_reg] <= rate;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

// ===== rtl/frame_rate_moving_average.sv =====
// A frame item passes through multiply, rate divide, window update and mean divide; the
// block takes no new item until that result has loaded, and waits longer while a result
// is stalled. An init item clears the window without leaving idle. Two serial dividers run
// in turn: rate (one step per rate bit, speed multiplies finish under it) then mean (one
// per sum bit). Reset: gains return to 5 and 3, last time, slot, fill and sum clear to zero;
// the rate memory is not cleared; its read data is used only once a full window is written.
// ----------------------------------------------------------------------------
// Frame rate moving average
// Measures frame intervals, derives speeds and a windowed mean frame rate.
// ----------------------------------------------------------------------------
`include "frame_rate_moving_average_defines.svh"

module frame_rate_moving_average #(
    parameter int WINDOW = frma_pkg::WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    output logic                             frame_stall,
    input  frma_pkg::frame_item_t            frame,
    output logic                             result_valid,
    input  logic                             result_stall,
    output frma_pkg::result_item_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [frma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frma_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import frma_pkg::*;

    localparam int FILL_W = fill_width(WINDOW);
    localparam int SUM_W  = sum_width(WINDOW);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]  move_gain_reg;
    logic [GAIN_W-1:0]  turn_gain_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  interval_reg;
    logic [PROD_W-1:0]  move_prod_reg;
    logic [PROD_W-1:0]  turn_prod_reg;
    logic [PART_W-1:0]  move_lo_reg, move_hi_reg;
    logic [PART_W-1:0]  turn_lo_reg, turn_hi_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [SPEED_W-1:0] move_reg;
    logic [SPEED_W-1:0] turn_reg;
    result_item_t       result_reg;
    logic               result_valid_reg;

    logic               frame_acc;
    logic               div_go;
    logic               avg_go;
    logic               divs_idle;
    logic               div_capture;
    logic               result_load;
    win_ctrl_t          win_ctrl;

    logic               rate_busy, avg_busy;
    logic [RATE_W-1:0]       rate_quot;
    logic [RECIP_HALF_W-1:0] recip_half;
    logic [PART_W-1:0]       move_part, turn_part;
    logic [ACC_W-1:0]        move_acc, turn_acc;
    logic [SUM_W-1:0]        avg_quot;
    logic [SUM_W-1:0]        win_sum;
    logic [FILL_W-1:0]       win_fill;

    assign frame_stall  = (state_reg != ST_IDLE);
    assign frame_acc    = frame_valid && !frame_stall;
    assign cfg_ready    = 1'b1;
    assign divs_idle    = !rate_busy;
    assign div_capture  = (state_reg == ST_DIV) && divs_idle;

    // Clear the window on an init item; sequence a frame item through multiply, divide, update, average
    always_comb
    begin
        state_next  = state_reg;
        win_ctrl    = '0;
        div_go      = 1'b0;
        avg_go      = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_acc)
                begin
                    if (frame.opcode == OP_INIT)
                    begin
                        win_ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        win_ctrl.rd = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_go     = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (divs_idle)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                win_ctrl.upd = 1'b1;
                state_next   = ST_AVGGO;
            end
            ST_AVGGO:
            begin
                avg_go     = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (!avg_busy && (!result_valid_reg || !result_stall))
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, gains and recorded time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            move_gain_reg    <= MOVE_GAIN_RST;
            turn_gain_reg    <= TURN_GAIN_RST;
            last_time_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MOVE_GAIN: move_gain_reg <= cfg_data;
                    CFG_TURN_GAIN: turn_gain_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (frame_acc)
            begin
                last_time_reg <= frame.time_ms;
            end
        end
    end

    // Speed scaling: low reciprocal half in the start cycle, high half while dividing
    assign recip_half = (state_reg == ST_DIVGO) ? SPEED_RECIP[RECIP_HALF_W-1:0]
                                                : SPEED_RECIP[RECIP_W-1:RECIP_HALF_W];
    assign move_part  = {{RECIP_HALF_W{1'b0}}, move_prod_reg[PROD_KEEP_W-1:0]} *
                        {{PROD_KEEP_W{1'b0}}, recip_half};
    assign turn_part  = {{RECIP_HALF_W{1'b0}}, turn_prod_reg[PROD_KEEP_W-1:0]} *
                        {{PROD_KEEP_W{1'b0}}, recip_half};
    assign move_acc   = {move_hi_reg, {RECIP_HALF_W{1'b0}}} + {{RECIP_HALF_W{1'b0}}, move_lo_reg};
    assign turn_acc   = {turn_hi_reg, {RECIP_HALF_W{1'b0}}} + {{RECIP_HALF_W{1'b0}}, turn_lo_reg};

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            interval_reg <= frame.time_ms - last_time_reg;
        end
        if (state_reg == ST_MUL)
        begin
            move_prod_reg <= {{GAIN_W{1'b0}}, interval_reg} * {{TIME_W{1'b0}}, move_gain_reg};
            turn_prod_reg <= {{GAIN_W{1'b0}}, interval_reg} * {{TIME_W{1'b0}}, turn_gain_reg};
        end
        if (state_reg == ST_DIVGO)
        begin
            move_lo_reg <= move_part;
            turn_lo_reg <= turn_part;
        end
        if (state_reg == ST_DIV)
        begin
            move_hi_reg <= move_part;
            turn_hi_reg <= turn_part;
        end
        if (div_capture)
        begin
            rate_reg <= (interval_reg == '0) ? RATE_MAX_Q8 : rate_quot;
            move_reg <= (move_prod_reg >= SPEED_SAT_LIMIT) ? '1
                                                           : move_acc[RECIP_SHIFT +: SPEED_W];
            turn_reg <= (turn_prod_reg >= SPEED_SAT_LIMIT) ? '1
                                                           : turn_acc[RECIP_SHIFT +: SPEED_W];
        end
        if (result_load)
        begin
            result_reg.average_rate <= avg_quot[RATE_W-1:0];
            result_reg.move_speed   <= move_reg;
            result_reg.turn_speed   <= turn_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Instantaneous rate: 256000 / interval
    frma_div #(
        .NUM_W (RATE_W),
        .DEN_W (TIME_W)
    ) u_rate_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (RATE_MAX_Q8),
        .den   (interval_reg),
        .busy  (rate_busy),
        .quot  (rate_quot)
    );

    // Mean rate: running sum / fill count
    frma_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_avg_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (avg_go),
        .num   (win_sum),
        .den   (win_fill),
        .busy  (avg_busy),
        .quot  (avg_quot)
    );

    frma_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (win_ctrl),
        .rate  (rate_reg),
        .sum   (win_sum),
        .fill  (win_fill)
    );

    // Checks
    `FRMA_ASSERT_IMP(a_accept_units_idle, frame_acc, divs_idle && !avg_busy, "item accepted while a divider runs")
    `FRMA_ASSERT_IMP(a_avg_fill_nonzero, state_reg == ST_AVGGO, win_fill != '0, "average started on an empty window")
    `FRMA_ASSERT_NXT(a_avg_go_busy, avg_go, avg_busy, "average divider did not start")
    `FRMA_ASSERT_IMP(a_rate_range, state_reg == ST_UPD, rate_reg <= RATE_MAX_Q8, "rate above 1000 fps")

endmodule

// ===== verif/tb_frame_rate_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate moving average: testbench
// Sends init and frame timestamps with bursty traffic and a stalling result
// side. Each result is checked field by field against a fixed value or a local model
// of the interval, speed and windowed mean rate math. Gains are swept between phases.
// ----------------------------------------------------------------------------
module tb_frame_rate_moving_average;

    import frma_pkg::*;

    localparam int WINDOW         = WINDOW_DEF;
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int SETTLE_CYCLES  = 100;
    localparam int IDLE_LIMIT     = 2000;

    typedef struct {
        logic         opcode;
        logic [31:0]  stamp;
        bit           fixed;
        result_item_t want;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          frame_valid = 1'b0;
    logic          frame_stall;
    frame_item_t   frame = '0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    result_item_t  result;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model state
    logic [31:0]       prev_stamp;
    logic [RATE_W-1:0] rate_ring [WINDOW];
    int unsigned       ring_pos;
    int unsigned       ring_fill;
    int unsigned       rate_total;
    logic [7:0]        move_gain_q;
    logic [7:0]        turn_gain_q;

    result_item_t pending_results [$];
    result_item_t due_result;
    stim_row_t    stim_rows [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    logic [31:0]  stamp_cursor = '0;
    int           stall_hold = 0;

    frame_rate_moving_average #(.WINDOW(WINDOW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Interval seconds times gain in Q16, saturated to 32 bits
    function automatic logic [31:0] scaled_speed(input logic [31:0] span,
                                                 input logic [7:0] gain);
        logic [63:0] prod;
        prod = ({32'd0, span} * {56'd0, gain} * 64'd65536) / 64'd1000;
        return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    // Advance the model by one item; return 1 when it yields a result
    function automatic bit predict_frame(input frame_item_t item,
                                         output result_item_t res);
        logic [31:0]       span;
        logic [RATE_W-1:0] rate;
        res = '0;
        if (item.opcode == OP_INIT)
        begin
            ring_pos   = 0;
            ring_fill  = 0;
            rate_total = 0;
            prev_stamp = item.time_ms;
            return 1'b0;
        end
        span       = item.time_ms - prev_stamp;
        prev_stamp = item.time_ms;
        rate = (span == 0) ? RATE_MAX_Q8 : RATE_W'({14'd0, RATE_MAX_Q8} / span);
        // Evict the oldest entry once the window is full
        if (ring_fill == WINDOW)
            rate_total -= rate_ring[ring_pos];
        else
            ring_fill++;
        rate_ring[ring_pos] = rate;
        rate_total += rate;
        ring_pos = (ring_pos + 1) % WINDOW;
        res.average_rate = RATE_W'(rate_total / ring_fill);
        res.move_speed   = scaled_speed(span, move_gain_q);
        res.turn_speed   = scaled_speed(span, turn_gain_q);
        return 1'b1;
    endfunction

    function automatic void add_row(input logic op, input logic [31:0] stamp,
                                    input bit fixed, input logic [RATE_W-1:0] avg,
                                    input logic [31:0] mv, input logic [31:0] tn);
        stim_row_t row;
        row.opcode = op;
        row.stamp  = stamp;
        row.fixed  = fixed;
        row.want.average_rate = avg;
        row.want.move_speed   = mv;
        row.want.turn_speed   = tn;
        stim_rows.push_back(row);
    endfunction

    // Drive one item, hold it until accepted, then queue its expected result if it yields one
    task automatic push_item(input frame_item_t item, input bit fixed,
                             input result_item_t want);
        result_item_t res;
        frame       <= item;
        frame_valid <= 1'b1;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        if (predict_frame(item, res))
            pending_results.push_back(fixed ? want : res);
    endtask

    // End a burst with a random gap, or keep streaming
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90)
                                               : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for all results, then let any init item finish
    task automatic drain();
        frame_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_gains(input logic [7:0] mv, input logic [7:0] tn);
        cfg_write(CFG_MOVE_GAIN, mv);
        cfg_write(CFG_TURN_GAIN, tn);
        cfg_valid   <= 1'b0;
        move_gain_q = mv;
        turn_gain_q = tn;
    endtask

    // Mostly frame items with a spread of intervals; rare init items
    function automatic frame_item_t random_item();
        frame_item_t item;
        logic [31:0] span;
        int          pick;
        pick = $urandom_range(0, 99);
        item.opcode = OP_FRAME;
        if (pick < 6)
        begin
            item.opcode = OP_INIT;
            span = (pick < 2) ? $urandom : 32'd0;
        end
        else if (pick < 14)
            span = 32'd0;
        else if (pick < 50)
            span = $urandom_range(1, 40);
        else if (pick < 70)
            span = $urandom_range(41, 400000);
        else if (pick < 82 && move_gain_q != 0)
            span = 32'd65536000 / move_gain_q + $urandom_range(0, 4) - 2;
        else
            span = $urandom;
        item.time_ms = stamp_cursor + span;
        stamp_cursor = item.time_ms;
        return item;
    endfunction

    // Result side stall pattern: clear stretches, short flicker, long holds
    always @(posedge clk)
    begin
        int pick;
        if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                result_stall <= 1'b0;
                stall_hold   <= $urandom_range(0, 40);
            end
            else if (pick < 80)
            begin
                result_stall <= 1'($urandom_range(0, 1));
                stall_hold   <= $urandom_range(0, 3);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_hold   <= $urandom_range(5, 25);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result avg %0d move %0d turn %0d", $time,
                         result.average_rate, result.move_speed, result.turn_speed);
                error_count++;
            end
            else
            begin
                due_result = pending_results.pop_front();
                if (result.average_rate !== due_result.average_rate)
                begin
                    $display("%0t: average_rate expected %0d, got %0d", $time,
                             due_result.average_rate, result.average_rate);
                    error_count++;
                end
                if (result.move_speed !== due_result.move_speed)
                begin
                    $display("%0t: move_speed expected %0d, got %0d", $time,
                             due_result.move_speed, result.move_speed);
                    error_count++;
                end
                if (result.turn_speed !== due_result.turn_speed)
                begin
                    $display("%0t: turn_speed expected %0d, got %0d", $time,
                             due_result.turn_speed, result.turn_speed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("** frame_rate_moving_average: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [31:0]  stamp;
        result_item_t none;
        frame_item_t  item;
        none = '0;

        // Model matches the block's reset state
        prev_stamp  = '0;
        ring_pos    = 0;
        ring_fill   = 0;
        rate_total  = 0;
        move_gain_q = MOVE_GAIN_RST;
        turn_gain_q = TURN_GAIN_RST;

        // Directed rows: frame before init, zero interval, longest interval,
        // saturation edge, time wrap, full window with a zero rate and eviction
        add_row(OP_FRAME, 32'd0, 1'b1, RATE_MAX_Q8, 32'd0, 32'd0);
        add_row(OP_INIT, 32'd1000, 1'b0, '0, '0, '0);
        add_row(OP_FRAME, 32'd1000, 1'b1, RATE_MAX_Q8, 32'd0, 32'd0);
        add_row(OP_INIT, 32'd0, 1'b0, '0, '0, '0);
        add_row(OP_FRAME, 32'hFFFF_FFFF, 1'b1, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(OP_INIT, 32'd0, 1'b0, '0, '0, '0);
        add_row(OP_FRAME, 32'd13107200, 1'b0, '0, '0, '0);
        add_row(OP_FRAME, 32'd26214399, 1'b0, '0, '0, '0);
        add_row(OP_INIT, 32'hFFFF_FFF0, 1'b0, '0, '0, '0);
        add_row(OP_FRAME, 32'h0000_0010, 1'b0, '0, '0, '0);
        stamp = 32'h0000_0010;
        for (int k = 0; k < WINDOW; k++)
        begin
            stamp += (k == 6) ? 32'd300000 : 32'(k + 1);
            add_row(OP_FRAME, stamp, 1'b0, '0, '0, '0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            item.opcode  = stim_rows[i].opcode;
            item.time_ms = stim_rows[i].stamp;
            push_item(item, stim_rows[i].fixed, stim_rows[i].want);
            pace();
        end
        stamp_cursor = prev_stamp;

        // Random phases, each under its own gain setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                drain();
                case (phase)
                    1: set_gains(8'd0, 8'd255);
                    2: set_gains(8'd255, 8'd0);
                    3: set_gains(8'd255, 8'd255);
                    4: set_gains(8'd1, 8'd1);
                    default: set_gains(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
                endcase
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                push_item(random_item(), 1'b0, none);
                pace();
            end
        end

        drain();
        if (error_count == 0)
            $display("** frame_rate_moving_average: PASSED **");
        else
            $display("** frame_rate_moving_average: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/frma_pkg.sv
rtl/frma_div.sv
rtl/frma_window.sv
rtl/frame_rate_moving_average.sv
verif/tb_frame_rate_moving_average.sv
